// ===== hdl/hzc_pkg.sv =====
package hzc_pkg;

  localparam int NSTAGE = 7;
  localparam int S_IF1  = 0;
  localparam int S_ID   = 2;
  localparam int S_EX   = 3;
  localparam int S_MEM1 = 4;
  localparam int S_MEM2 = 5;
  localparam int S_WB   = 6;

  localparam int DEF_SQUASH_SLOTS = 3;
  localparam int DEF_ADDR_WIDTH   = 32;

  localparam logic [3:0] KIND_NOP      = 4'd0;
  localparam logic [3:0] KIND_RTYPE    = 4'd1;
  localparam logic [3:0] KIND_ITYPE    = 4'd2;
  localparam logic [3:0] KIND_LOAD     = 4'd3;
  localparam logic [3:0] KIND_STORE    = 4'd4;
  localparam logic [3:0] KIND_BRANCH   = 4'd5;
  localparam logic [3:0] KIND_JTYPE    = 4'd6;
  localparam logic [3:0] KIND_SPECIAL  = 4'd7;
  localparam logic [3:0] KIND_JRTYPE   = 4'd8;
  localparam logic [3:0] KIND_SQUASHED = 4'd9;

  localparam logic [2:0] CAUSE_NORMAL  = 3'd0;
  localparam logic [2:0] CAUSE_STRUCT  = 3'd1;
  localparam logic [2:0] CAUSE_LU_MEM1 = 3'd2;
  localparam logic [2:0] CAUSE_LU_MEM2 = 3'd3;
  localparam logic [2:0] CAUSE_FREEZE  = 3'd4;
  localparam logic [2:0] CAUSE_SQUASH  = 3'd5;

  localparam logic [31:0] CNT_MAX = 32'hffff_ffff;

  // consumer of the given kind reads register r
  function automatic logic reads_reg(input logic [3:0] kind, input logic [4:0] ra,
                                     input logic [4:0] rb, input logic [4:0] r);
    logic hit;
    hit = 1'b0;
    case (kind)
      KIND_ITYPE, KIND_JRTYPE:           hit = (ra == r);
      KIND_RTYPE, KIND_STORE, KIND_BRANCH: hit = (ra == r) || (rb == r);
      default:                           hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ===== hdl/hzc_if.sv =====
interface hzc_offer_if;
  logic        valid;
  logic        ready;
  logic        offer_valid;
  logic [3:0]  instr_kind;
  logic [4:0]  src_reg_a;
  logic [4:0]  src_reg_b;
  logic [4:0]  dest_reg;
  logic [31:0] instr_pc;
  logic [31:0] instr_addr;

  modport source(output valid, offer_valid, instr_kind, src_reg_a, src_reg_b, dest_reg,
                 instr_pc, instr_addr, input ready);
  modport sink(input valid, offer_valid, instr_kind, src_reg_a, src_reg_b, dest_reg,
               instr_pc, instr_addr, output ready);
endinterface

interface hzc_result_if;
  logic        valid;
  logic        ready;
  logic        offer_taken;
  logic [2:0]  tick_cause;
  logic [3:0]  wb_kind;
  logic [4:0]  wb_src_a;
  logic [4:0]  wb_src_b;
  logic [4:0]  wb_dest;
  logic [31:0] wb_pc;
  logic [31:0] wb_addr;
  logic [31:0] bubble_count;
  logic [31:0] squash_count;

  modport source(output valid, offer_taken, tick_cause, wb_kind, wb_src_a, wb_src_b,
                 wb_dest, wb_pc, wb_addr, bubble_count, squash_count, input ready);
  modport sink(input valid, offer_taken, tick_cause, wb_kind, wb_src_a, wb_src_b,
               wb_dest, wb_pc, wb_addr, bubble_count, squash_count, output ready);
endinterface

// ===== hdl/seven_stage_pipeline_hazard_control_core.sv =====
// Hazard control for a seven-stage in-order pipeline (IF1 IF2 ID EX MEM1 MEM2 WB).
// Each request on the offer channel is one pipeline tick: it may carry a fetched
// instruction (offer_valid) that enters IF1 if the tick advances normally.
// The result channel returns exactly one response per request: whether the offer
// was taken, the cause of the tick, the contents of WB after the tick and
// saturating counts of hazard bubbles and squashed bubbles.
// The response is registered: it is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while responses are taken; the whole tick decision is one level of
// compare and select logic between the stage registers and the response register.
// The response register lets a new request in during the same cycle in which the
// previous response is taken; while the receiver stalls with a response pending,
// offer.ready stays low and the pipeline state holds.
// Reset (synchronous, active high) empties the pipe to NOPs, clears the squash
// countdown and both counters, and drops the response valid.
// A branch or jtype in EX whose address matches the ID PC freezes one tick,
// then SQUASH_SLOTS ticks (taken modulo 4) inject squashed bubbles into EX.
module seven_stage_pipeline_hazard_control_core #(
  parameter int SQUASH_SLOTS = hzc_pkg::DEF_SQUASH_SLOTS,
  parameter int ADDR_WIDTH   = hzc_pkg::DEF_ADDR_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  hzc_offer_if.sink     offer,
  hzc_result_if.source  result
);
  import hzc_pkg::*;

  typedef struct packed {
    logic [3:0]            kind;
    logic [4:0]            ra;
    logic [4:0]            rb;
    logic [4:0]            rd;
    logic [ADDR_WIDTH-1:0] pc;
    logic [ADDR_WIDTH-1:0] addr;
  } stage_t;

  localparam stage_t NOP_STAGE = '{kind: KIND_NOP, default: '0};
  localparam stage_t SQ_STAGE  = '{kind: KIND_SQUASHED, default: '0};

  stage_t      stage [NSTAGE];
  stage_t      stage_next [NSTAGE];
  logic [1:0]  squash_left, squash_left_next;
  logic [31:0] bubble_counter, bubble_counter_next;
  logic [31:0] squash_counter, squash_counter_next;
  logic        rvalid;
  logic        taken, taken_next;
  logic [2:0]  cause, cause_next;

  logic        accept;
  logic        freeze;
  logic [2:0]  hazard;
  stage_t      fetched;
  logic [63:0] pc_ext, addr_ext, wb_pc_ext, wb_addr_ext;

  assign offer.ready = !rvalid || result.ready;
  assign accept      = offer.valid && offer.ready;

  assign freeze = ((stage[S_EX].kind == KIND_BRANCH) || (stage[S_EX].kind == KIND_JTYPE)) &&
                  (stage[S_EX].addr == stage[S_ID].pc);

  always_comb begin
    if (stage[S_MEM1].kind == KIND_LOAD &&
        reads_reg(stage[S_EX].kind, stage[S_EX].ra, stage[S_EX].rb, stage[S_MEM1].rd)) begin
      hazard = CAUSE_LU_MEM1;
    end else if (stage[S_MEM2].kind == KIND_LOAD &&
        reads_reg(stage[S_EX].kind, stage[S_EX].ra, stage[S_EX].rb, stage[S_MEM2].rd)) begin
      hazard = CAUSE_LU_MEM2;
    end else if ((stage[S_WB].kind == KIND_RTYPE || stage[S_WB].kind == KIND_ITYPE) &&
        reads_reg(stage[S_ID].kind, stage[S_ID].ra, stage[S_ID].rb, stage[S_WB].rd)) begin
      hazard = CAUSE_STRUCT;
    end else begin
      hazard = CAUSE_NORMAL;
    end
  end

  assign pc_ext   = {32'd0, offer.instr_pc};
  assign addr_ext = {32'd0, offer.instr_addr};

  always_comb begin
    fetched = NOP_STAGE;
    if (offer.offer_valid && offer.instr_kind <= KIND_JRTYPE) begin
      fetched.kind = offer.instr_kind;
      fetched.ra   = offer.src_reg_a;
      fetched.rb   = offer.src_reg_b;
      fetched.rd   = offer.dest_reg;
      fetched.pc   = pc_ext[ADDR_WIDTH-1:0];
      fetched.addr = addr_ext[ADDR_WIDTH-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < NSTAGE; i++) begin
      stage_next[i] = stage[i];
    end
    squash_left_next    = squash_left;
    bubble_counter_next = bubble_counter;
    squash_counter_next = squash_counter;
    taken_next          = 1'b0;
    cause_next          = CAUSE_NORMAL;
    if (squash_left != 2'd0) begin
      squash_left_next = squash_left - 2'd1;
      if (squash_counter != CNT_MAX) begin
        squash_counter_next = squash_counter + 32'd1;
      end
      for (int i = S_WB; i > S_EX; i--) begin
        stage_next[i] = stage[i-1];
      end
      stage_next[S_EX] = SQ_STAGE;
      cause_next = CAUSE_SQUASH;
    end else if (freeze) begin
      squash_left_next = 2'(SQUASH_SLOTS);
      cause_next = CAUSE_FREEZE;
    end else begin
      cause_next = hazard;
      case (hazard)
        CAUSE_NORMAL: begin
          for (int i = S_WB; i > S_IF1; i--) begin
            stage_next[i] = stage[i-1];
          end
          stage_next[S_IF1] = fetched;
          taken_next = offer.offer_valid;
        end
        CAUSE_LU_MEM1: begin
          stage_next[S_WB]   = stage[S_MEM2];
          stage_next[S_MEM2] = stage[S_MEM1];
          stage_next[S_MEM1] = NOP_STAGE;
        end
        CAUSE_LU_MEM2: begin
          stage_next[S_WB]   = stage[S_MEM2];
          stage_next[S_MEM2] = NOP_STAGE;
        end
        default: begin
          stage_next[S_WB]   = stage[S_MEM2];
          stage_next[S_MEM2] = stage[S_MEM1];
          stage_next[S_MEM1] = stage[S_EX];
          stage_next[S_EX]   = NOP_STAGE;
        end
      endcase
      if (hazard != CAUSE_NORMAL && bubble_counter != CNT_MAX) begin
        bubble_counter_next = bubble_counter + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTAGE; i++) begin
        stage[i] <= NOP_STAGE;
      end
      squash_left    <= 2'd0;
      bubble_counter <= 32'd0;
      squash_counter <= 32'd0;
      rvalid         <= 1'b0;
      taken          <= 1'b0;
      cause          <= CAUSE_NORMAL;
    end else begin
      if (accept) begin
        for (int i = 0; i < NSTAGE; i++) begin
          stage[i] <= stage_next[i];
        end
        squash_left    <= squash_left_next;
        bubble_counter <= bubble_counter_next;
        squash_counter <= squash_counter_next;
        taken          <= taken_next;
        cause          <= cause_next;
        rvalid         <= 1'b1;
      end else if (result.ready) begin
        rvalid <= 1'b0;
      end
    end
  end

  // state only moves on a request, so WB and counters hold the pending response
  assign wb_pc_ext   = 64'(stage[S_WB].pc);
  assign wb_addr_ext = 64'(stage[S_WB].addr);

  assign result.valid        = rvalid;
  assign result.offer_taken  = taken;
  assign result.tick_cause   = cause;
  assign result.wb_kind      = stage[S_WB].kind;
  assign result.wb_src_a     = stage[S_WB].ra;
  assign result.wb_src_b     = stage[S_WB].rb;
  assign result.wb_dest      = stage[S_WB].rd;
  assign result.wb_pc        = wb_pc_ext[31:0];
  assign result.wb_addr      = wb_addr_ext[31:0];
  assign result.bubble_count = bubble_counter;
  assign result.squash_count = squash_counter;

  a_squash_countdown: assert property (@(posedge clk) disable iff (rst)
    accept && squash_left != 2'd0 |=> squash_left == $past(squash_left) - 2'd1)
    else $error("squash countdown did not step");

  a_freeze_arms: assert property (@(posedge clk) disable iff (rst)
    accept && squash_left == 2'd0 && freeze |=> squash_left == 2'(SQUASH_SLOTS))
    else $error("freeze did not arm squash countdown");

  a_squash_fills_ex: assert property (@(posedge clk) disable iff (rst)
    accept && squash_left != 2'd0 |=> stage[S_EX].kind == KIND_SQUASHED &&
    cause == CAUSE_SQUASH)
    else $error("squash tick without squashed bubble in EX");

  a_taken_only_normal: assert property (@(posedge clk) disable iff (rst)
    rvalid && taken |-> cause == CAUSE_NORMAL)
    else $error("offer taken on a stalled tick");

endmodule
